// ===== rtl/assert_macros.svh =====
// Assertion macros for the rotator RTL, included by euler_point_rotator_unit.
// Depends on: a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EPR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("epr implication check failed");
`define EPR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("epr next-cycle check failed");
`else
`define EPR_ASSERT_IMP(lbl, ante, cons)
`define EPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/epr_pkg.sv =====
// Types, constants and helper functions of the Euler point rotator.
// Depends on: nothing.
`default_nettype none
package epr_pkg;

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] CFG_ANGLE_X  = 3'd3;
	localparam logic [2:0] CFG_ANGLE_Y  = 3'd4;
	localparam logic [2:0] CFG_ANGLE_Z  = 3'd5;

	localparam logic [63:0] PI_Q62   = 64'hC90F_DAA2_2168_C234;
	localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd11520;
	localparam logic [63:0] ONE_Q62  = 64'h4000_0000_0000_0000;
	localparam logic [63:0] HALF_Q30 = 64'h0000_0000_8000_0000;

	localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
	localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
	localparam logic signed [31:0] COS_ZERO     = 32'sh4000_0000;
	localparam logic [4:0]         LAST_LOOP_K  = 5'd23;

	typedef enum logic [3:0] {
		TS_IDLE,
		TS_MUL_X,
		TS_MUL_X2,
		TS_MUL_C,
		TS_DIV_C,
		TS_MUL_S,
		TS_DIV_S,
		TS_UPDATE,
		TS_FINISH
	} trig_state_t;

	typedef struct packed {
		logic signed [31:0] sin_x;
		logic signed [31:0] cos_x;
		logic signed [31:0] sin_y;
		logic signed [31:0] cos_y;
		logic signed [31:0] sin_z;
		logic signed [31:0] cos_z;
	} trig_t;

	typedef struct packed {
		logic mul;
		logic sum;
	} rot_en_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v);
		logic signed [63:0] t;
		logic signed [33:0] q;
		logic signed [31:0] r;
		t = v + 64'sd536870912;
		q = 34'(t >>> 30);
		if (q[33:31] == 3'b000 || q[33:31] == 3'b111) begin
			r = q[31:0];
		end else begin
			r = q[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/epr_trig.sv =====
// Sine/cosine sequencer: series evaluation in Q2.62 with a shared 32x32 multiplier
// and a radix-2 divider, rounded to Q2.30 per axis. Depends on: epr_pkg.
`default_nettype none
module epr_trig
	import epr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic        [2:0]  angle_wr,
	input  wire logic signed [15:0] ang_x,
	input  wire logic signed [15:0] ang_y,
	input  wire logic signed [15:0] ang_z,
	output trig_t                   trig,
	output logic                    busy
);

	trig_state_t state_q, state_d;
	logic [2:0]   pend_q;
	logic [2:0]   pend_clr;
	logic [1:0]   sel;
	logic [1:0]   axis_q;
	logic [1:0]   quad_q;
	logic [1:0]   quad;
	logic signed [15:0] ang;
	logic signed [16:0] t0, t1, t2, m;
	logic [12:0]  r;

	logic [63:0]  ma_q, mb_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;
	logic [2:0]   mcnt_q;
	logic [63:0]  pp_next;
	logic [127:0] addend;
	logic [63:0]  prod;
	logic         mul_st, mul_done;

	logic [63:0]  dn_q;
	logic [9:0]   rem_q;
	logic [9:0]   dd_q;
	logic [6:0]   dcnt_q;
	logic [10:0]  rs;
	logic         ge;
	logic [10:0]  rdiff;
	logic         div_st, div_done;

	logic [63:0]  x2_q, ct_q, st_q, csum_q, ssum_q;
	logic [4:0]   k_q;
	logic         neg_q;
	logic [11:0]  den_c, den_s;
	logic [63:0]  s_rnd, c_rnd;
	logic signed [31:0] s0, c0, s_fin, c_fin;

	always_comb begin
		if (pend_q[0]) begin
			sel = 2'd0;
			ang = ang_x;
		end else if (pend_q[1]) begin
			sel = 2'd1;
			ang = ang_y;
		end else begin
			sel = 2'd2;
			ang = ang_z;
		end
		t0 = {ang[15], ang};
		t1 = t0[16] ? t0 + FULL_TURN : t0;
		t2 = t1[16] ? t1 + FULL_TURN : t1;
		m  = (t2 >= FULL_TURN) ? t2 - FULL_TURN : t2;
		if (m >= 3 * QUARTER_TURN) begin
			quad = 2'd3;
			r = 13'(m - 3 * QUARTER_TURN);
		end else if (m >= 2 * QUARTER_TURN) begin
			quad = 2'd2;
			r = 13'(m - 2 * QUARTER_TURN);
		end else if (m >= QUARTER_TURN) begin
			quad = 2'd1;
			r = 13'(m - QUARTER_TURN);
		end else begin
			quad = 2'd0;
			r = 13'(m);
		end
	end

	always_comb begin
		case (mcnt_q)
			3'd0: pp_next = 64'(ma_q[31:0]) * 64'(mb_q[31:0]);
			3'd1: pp_next = 64'(ma_q[31:0]) * 64'(mb_q[63:32]);
			3'd2: pp_next = 64'(ma_q[63:32]) * 64'(mb_q[31:0]);
			3'd3: pp_next = 64'(ma_q[63:32]) * 64'(mb_q[63:32]);
			default: pp_next = pp_q;
		endcase
		case (mcnt_q)
			3'd1: addend = {64'd0, pp_q};
			3'd2: addend = {32'd0, pp_q, 32'd0};
			3'd3: addend = {32'd0, pp_q, 32'd0};
			3'd4: addend = {pp_q, 64'd0};
			default: addend = '0;
		endcase
		prod  = acc_q[125:62];
		rs    = {rem_q, dn_q[63]};
		ge    = rs >= {1'b0, dd_q};
		rdiff = rs - {1'b0, dd_q};
		den_c = 12'(k_q) * (12'(k_q) + 12'd1);
		den_s = (12'(k_q) + 12'd1) * (12'(k_q) + 12'd2);
		s_rnd = ssum_q + HALF_Q30;
		c_rnd = csum_q + HALF_Q30;
		s0    = s_rnd[63:32];
		c0    = c_rnd[63:32];
		case (quad_q)
			2'd0: begin s_fin = s0;  c_fin = c0;  end
			2'd1: begin s_fin = c0;  c_fin = -s0; end
			2'd2: begin s_fin = -s0; c_fin = -c0; end
			default: begin s_fin = -c0; c_fin = s0; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			TS_IDLE:   if (pend_q != 3'd0) state_d = TS_MUL_X;
			TS_MUL_X:  if (mul_done) state_d = TS_MUL_X2;
			TS_MUL_X2: if (mul_done) state_d = TS_MUL_C;
			TS_MUL_C:  if (mul_done) state_d = TS_DIV_C;
			TS_DIV_C:  if (div_done) state_d = TS_MUL_S;
			TS_MUL_S:  if (mul_done) state_d = TS_DIV_S;
			TS_DIV_S:  if (div_done) state_d = TS_UPDATE;
			TS_UPDATE: state_d = (k_q <= LAST_LOOP_K) ? TS_MUL_C : TS_FINISH;
			TS_FINISH: state_d = TS_IDLE;
			default:   state_d = TS_IDLE;
		endcase
	end

	always_comb begin
		mul_st   = (state_q == TS_MUL_X) || (state_q == TS_MUL_X2) ||
			(state_q == TS_MUL_C) || (state_q == TS_MUL_S);
		div_st   = (state_q == TS_DIV_C) || (state_q == TS_DIV_S);
		mul_done = mcnt_q == 3'd5;
		div_done = dcnt_q == 7'd64;
		busy     = (state_q != TS_IDLE) || (pend_q != 3'd0);
		pend_clr = 3'd0;
		if (state_q == TS_IDLE && pend_q != 3'd0) begin
			pend_clr[sel] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			pend_q  <= 3'd0;
			trig    <= '{sin_x: 32'sd0, cos_x: COS_ZERO, sin_y: 32'sd0,
				cos_y: COS_ZERO, sin_z: 32'sd0, cos_z: COS_ZERO};
		end else begin
			state_q <= state_d;
			pend_q  <= (pend_q & ~pend_clr) | angle_wr;
			if (state_q == TS_FINISH) begin
				case (axis_q)
					2'd0: begin trig.sin_x <= s_fin;  trig.cos_x <= c_fin; end
					2'd1: begin trig.sin_y <= -s_fin; trig.cos_y <= c_fin; end
					default: begin trig.sin_z <= s_fin; trig.cos_z <= c_fin; end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_st && !mul_done) begin
			mcnt_q <= mcnt_q + 3'd1;
			pp_q   <= pp_next;
			acc_q  <= acc_q + addend;
		end
		if (div_st && !div_done) begin
			dcnt_q <= dcnt_q + 7'd1;
			rem_q  <= ge ? rdiff[9:0] : rs[9:0];
			dn_q   <= {dn_q[62:0], ge};
		end
		case (state_q)
			TS_IDLE: begin
				ma_q   <= STEP_Q62;
				mb_q   <= {51'd0, r};
				acc_q  <= '0;
				mcnt_q <= 3'd0;
				quad_q <= quad;
				axis_q <= sel;
			end
			TS_MUL_X: if (mul_done) begin
				ssum_q <= acc_q[63:0];
				st_q   <= acc_q[63:0];
				ma_q   <= acc_q[63:0];
				mb_q   <= acc_q[63:0];
				acc_q  <= '0;
				mcnt_q <= 3'd0;
			end
			TS_MUL_X2: if (mul_done) begin
				x2_q   <= prod;
				csum_q <= ONE_Q62;
				ct_q   <= ONE_Q62;
				k_q    <= 5'd1;
				neg_q  <= 1'b1;
				ma_q   <= ONE_Q62;
				mb_q   <= prod;
				acc_q  <= '0;
				mcnt_q <= 3'd0;
			end
			TS_MUL_C: if (mul_done) begin
				dn_q   <= prod;
				rem_q  <= 10'd0;
				dd_q   <= den_c[9:0];
				dcnt_q <= 7'd0;
			end
			TS_DIV_C: if (div_done) begin
				ct_q   <= dn_q;
				ma_q   <= st_q;
				mb_q   <= x2_q;
				acc_q  <= '0;
				mcnt_q <= 3'd0;
			end
			TS_MUL_S: if (mul_done) begin
				dn_q   <= prod;
				rem_q  <= 10'd0;
				dd_q   <= den_s[9:0];
				dcnt_q <= 7'd0;
			end
			TS_DIV_S: if (div_done) begin
				st_q <= dn_q;
			end
			TS_UPDATE: begin
				csum_q <= neg_q ? csum_q - ct_q : csum_q + ct_q;
				ssum_q <= neg_q ? ssum_q - st_q : ssum_q + st_q;
				neg_q  <= ~neg_q;
				k_q    <= k_q + 5'd2;
				ma_q   <= ct_q;
				mb_q   <= x2_q;
				acc_q  <= '0;
				mcnt_q <= 3'd0;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/epr_rotate.sv =====
// One plane rotation in two stages: four products, then round and saturate.
// Depends on: epr_pkg.
`default_nettype none
module epr_rotate
	import epr_pkg::*;
(
	input  wire logic               clk,
	input  wire rot_en_t            en,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	input  wire logic signed [31:0] p,
	input  wire logic signed [31:0] c,
	input  wire logic signed [31:0] s,
	output logic signed [31:0]      ra,
	output logic signed [31:0]      rb,
	output logic signed [31:0]      rp
);

	logic signed [63:0] ca_s1, sb_s1, cb_s1, sa_s1;
	logic signed [31:0] p_s1;
	logic signed [31:0] ra_s2, rb_s2, rp_s2;

	always_ff @(posedge clk) begin
		if (en.mul) begin
			ca_s1 <= c * a;
			sb_s1 <= s * b;
			cb_s1 <= c * b;
			sa_s1 <= s * a;
			p_s1  <= p;
		end
		if (en.sum) begin
			ra_s2 <= rnd_sat(ca_s1 + sb_s1);
			rb_s2 <= rnd_sat(cb_s1 - sa_s1);
			rp_s2 <= p_s1;
		end
	end

	assign ra = ra_s2;
	assign rb = rb_s2;
	assign rp = rp_s2;

endmodule
`default_nettype wire

// ===== rtl/euler_point_rotator_unit.sv =====
// Euler point rotator: moves a Q16.16 point to the configured origin, rotates it
// about x, y and z, and moves it back. Input beat: px/py/pz under in_valid/in_ready.
// Output beat: rx/ry/rz under out_valid/out_ready. Registers are written through
// wr_en/wr_idx/wr_data (origin x/y/z at 0..2, angles x/y/z at 3..5, others dropped).
// An accepted beat passes through every stage register before out_valid rises; one beat
// per cycle is sustained while out_ready is high and no angle is pending.
// The path is eight register stages: origin subtract, three plane rotations of two
// stages each (products, then round and saturate), origin add into the output register.
// Each angle write starts the sine/cosine sequencer, which evaluates each angle in
// 13 series terms, each two 4-product multiplies and two 64-step divides;
// in_ready stays low until all pending angles are done. Reset clears all registers to
// zero (sine 0, cosine 1) and empties the pipeline; nothing needs recomputing.
// When out_ready is low the output holds; stages behind it keep filling bubbles and
// in_ready drops only once the pipeline is full or an angle is pending.
// Depends on: epr_pkg, epr_trig, epr_rotate, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module euler_point_rotator_unit
	import epr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] px,
	input  wire logic signed [31:0] py,
	input  wire logic signed [31:0] pz,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      rx,
	output logic signed [31:0]      ry,
	output logic signed [31:0]      rz,
	input  wire logic               wr_en,
	input  wire logic        [2:0]  wr_idx,
	input  wire logic        [31:0] wr_data
);

	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic signed [15:0] angle_x_q, angle_y_q, angle_z_q;
	logic [2:0]         angle_wr;
	trig_t              trig;
	logic               trig_busy;

	logic [8:1]         valid_q;
	logic [8:1]         en;
	rot_en_t            en_x, en_y, en_z;

	logic signed [31:0] x_s1, y_s1, z_s1;
	logic signed [31:0] y_s3, z_s3, x_s3;
	logic signed [31:0] x_s5, z_s5, y_s5;
	logic signed [31:0] x_s7, y_s7, z_s7;
	logic signed [31:0] rx_s8, ry_s8, rz_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			angle_x_q  <= '0;
			angle_y_q  <= '0;
			angle_z_q  <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				CFG_ORIGIN_X: origin_x_q <= wr_data;
				CFG_ORIGIN_Y: origin_y_q <= wr_data;
				CFG_ORIGIN_Z: origin_z_q <= wr_data;
				CFG_ANGLE_X:  angle_x_q  <= wr_data[15:0];
				CFG_ANGLE_Y:  angle_y_q  <= wr_data[15:0];
				CFG_ANGLE_Z:  angle_z_q  <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign angle_wr = {wr_en && wr_idx == CFG_ANGLE_Z, wr_en && wr_idx == CFG_ANGLE_Y,
		wr_en && wr_idx == CFG_ANGLE_X};

	epr_trig u_trig (
		.clk      (clk),
		.arst_n   (arst_n),
		.angle_wr (angle_wr),
		.ang_x    (angle_x_q),
		.ang_y    (angle_y_q),
		.ang_z    (angle_z_q),
		.trig     (trig),
		.busy     (trig_busy)
	);

	// advance a stage when it is empty or the next one advances
	always_comb begin
		en[8] = !valid_q[8] || out_ready;
		for (int i = 7; i >= 1; i--) begin
			en[i] = !valid_q[i] || en[i + 1];
		end
		en_x = '{mul: en[2], sum: en[3]};
		en_y = '{mul: en[4], sum: en[5]};
		en_z = '{mul: en[6], sum: en[7]};
	end

	assign in_ready  = en[1] && !trig_busy;
	assign out_valid = valid_q[8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) valid_q[1] <= in_valid && in_ready;
			for (int i = 2; i <= 8; i++) begin
				if (en[i]) valid_q[i] <= valid_q[i - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1 <= sat33(33'(px) - 33'(origin_x_q));
			y_s1 <= sat33(33'(py) - 33'(origin_y_q));
			z_s1 <= sat33(33'(pz) - 33'(origin_z_q));
		end
		if (en[8]) begin
			rx_s8 <= sat33(33'(x_s7) + 33'(origin_x_q));
			ry_s8 <= sat33(33'(y_s7) + 33'(origin_y_q));
			rz_s8 <= sat33(33'(z_s7) + 33'(origin_z_q));
		end
	end

	epr_rotate u_rot_x (
		.clk (clk), .en (en_x),
		.a (y_s1), .b (z_s1), .p (x_s1), .c (trig.cos_x), .s (trig.sin_x),
		.ra (y_s3), .rb (z_s3), .rp (x_s3)
	);

	// sin_y is stored negated, matching the y-axis sign convention
	epr_rotate u_rot_y (
		.clk (clk), .en (en_y),
		.a (x_s3), .b (z_s3), .p (y_s3), .c (trig.cos_y), .s (trig.sin_y),
		.ra (x_s5), .rb (z_s5), .rp (y_s5)
	);

	epr_rotate u_rot_z (
		.clk (clk), .en (en_z),
		.a (x_s5), .b (y_s5), .p (z_s5), .c (trig.cos_z), .s (trig.sin_z),
		.ra (x_s7), .rb (y_s7), .rp (z_s7)
	);

	assign rx = rx_s8;
	assign ry = ry_s8;
	assign rz = rz_s8;

	`EPR_ASSERT_IMP(a_no_beat_while_busy, trig_busy, !in_ready)
	`EPR_ASSERT_NXT(a_angle_starts_trig, wr_en && wr_idx == CFG_ANGLE_X, trig_busy)
	`EPR_ASSERT_NXT(a_beat_enters_s1, in_valid && in_ready, valid_q[1])

endmodule
`default_nettype wire

// ===== test/euler_point_rotator_checker.sv =====
// Checker for the Euler point rotator: follows register writes, predicts each rotated
// point from every accepted input beat and compares it with the output beats.
// Depends on: epr_pkg (register indexes and fixed-point constants).
module euler_point_rotator_checker
	import epr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] rx,
	input  logic signed [31:0] ry,
	input  logic signed [31:0] rz,
	input  logic               wr_en,
	input  logic        [2:0]  wr_idx,
	input  logic        [31:0] wr_data,
	output int                 mismatches,
	output int                 points_pending,
	output int                 points_checked
);

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct {
		longint s;
		longint c;
	} sincos_t;

	point_t rotated_q[$];
	logic signed [31:0] org_x, org_y, org_z;
	sincos_t rot_x, rot_y, rot_z;

	function automatic logic [63:0] mul_frac62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic sincos_t angle_sincos(input logic signed [15:0] ang);
		int a;
		int m;
		int quad;
		logic [63:0] xr, x2, ssum, st, csum, ct, s0, c0;
		bit neg;
		sincos_t r;
		a = ang;
		m = ((a % 23040) + 23040) % 23040;
		quad = m / 5760;
		xr = STEP_Q62 * 64'(m % 5760);
		x2 = mul_frac62(xr, xr);
		ssum = xr;
		st = xr;
		csum = ONE_Q62;
		ct = ONE_Q62;
		neg = 1'b1;
		for (int k = 1; k < 26; k += 2) begin
			ct = mul_frac62(ct, x2) / 64'(k * (k + 1));
			st = mul_frac62(st, x2) / 64'((k + 1) * (k + 2));
			if (neg) begin
				csum -= ct;
				ssum -= st;
			end else begin
				csum += ct;
				ssum += st;
			end
			neg = !neg;
		end
		s0 = (ssum + HALF_Q30) >> 32;
		c0 = (csum + HALF_Q30) >> 32;
		case (quad)
			0: begin r.s = s0; r.c = c0; end
			1: begin r.s = c0; r.c = -longint'(s0); end
			2: begin r.s = -longint'(s0); r.c = -longint'(c0); end
			default: begin r.s = -longint'(c0); r.c = s0; end
		endcase
		return r;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_q30(input longint v);
		logic [63:0] u;
		u = v + (64'd1 << 62) + (64'd1 << 29);
		return clamp32(longint'(u >> 30) - (64'sd1 <<< 32));
	endfunction

	function automatic point_t rotate_point(input point_t p);
		longint x, y, z, t1, t2;
		point_t r;
		x = clamp32(longint'(p.x) - org_x);
		y = clamp32(longint'(p.y) - org_y);
		z = clamp32(longint'(p.z) - org_z);
		t1 = round_q30(rot_x.c * y + rot_x.s * z);
		t2 = round_q30(rot_x.c * z - rot_x.s * y);
		y = t1;
		z = t2;
		t1 = round_q30(rot_y.c * x - rot_y.s * z);
		t2 = round_q30(rot_y.c * z + rot_y.s * x);
		x = t1;
		z = t2;
		t1 = round_q30(rot_z.c * x + rot_z.s * y);
		t2 = round_q30(rot_z.c * y - rot_z.s * x);
		r.x = 32'(clamp32(t1 + org_x));
		r.y = 32'(clamp32(t2 + org_y));
		r.z = 32'(clamp32(z + org_z));
		return r;
	endfunction

	initial begin
		mismatches = 0;
		points_checked = 0;
	end

	assign points_pending = rotated_q.size();

	always @(posedge clk or negedge arst_n) begin
		point_t got, want;
		if (!arst_n) begin
			org_x <= '0;
			org_y <= '0;
			org_z <= '0;
			rot_x <= angle_sincos(16'sd0);
			rot_y <= angle_sincos(16'sd0);
			rot_z <= angle_sincos(16'sd0);
		end else begin
			if (wr_en) begin
				case (wr_idx)
					CFG_ORIGIN_X: org_x <= wr_data;
					CFG_ORIGIN_Y: org_y <= wr_data;
					CFG_ORIGIN_Z: org_z <= wr_data;
					CFG_ANGLE_X:  rot_x <= angle_sincos(wr_data[15:0]);
					CFG_ANGLE_Y:  rot_y <= angle_sincos(wr_data[15:0]);
					CFG_ANGLE_Z:  rot_z <= angle_sincos(wr_data[15:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				got.x = px;
				got.y = py;
				got.z = pz;
				rotated_q.push_back(rotate_point(got));
			end
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: unexpected output beat %h %h %h", $time, rx, ry, rz);
					mismatches++;
				end else begin
					want = rotated_q.pop_front();
					points_checked++;
					if (rx !== want.x) begin
						$display("%0t: rx expected %h actual %h", $time, want.x, rx);
						mismatches++;
					end
					if (ry !== want.y) begin
						$display("%0t: ry expected %h actual %h", $time, want.y, ry);
						mismatches++;
					end
					if (rz !== want.z) begin
						$display("%0t: rz expected %h actual %h", $time, want.z, rz);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

// ===== test/euler_point_rotator_unit_tb.sv =====
// Testbench top for euler_point_rotator_unit: drives points and register writes with
// random idling on both channels and gives the verdict from the checker's count.
// Depends on: epr_pkg, euler_point_rotator_unit, euler_point_rotator_checker.
module euler_point_rotator_unit_tb
	import epr_pkg::*;
;

	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] px = '0, py = '0, pz = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] rx, ry, rz;
	logic wr_en = 1'b0;
	logic [2:0] wr_idx = '0;
	logic [31:0] wr_data = '0;
	int mismatches, points_pending, points_checked;
	int cycles = 0;
	int settings_run = 0;
	bit steady = 1'b0;

	always #5 clk = ~clk;

	euler_point_rotator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .px(px), .py(py), .pz(pz),
		.out_valid(out_valid), .out_ready(out_ready), .rx(rx), .ry(ry), .rz(rz),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	euler_point_rotator_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .px(px), .py(py), .pz(pz),
		.out_valid(out_valid), .out_ready(out_ready), .rx(rx), .ry(ry), .rz(rz),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
		.mismatches(mismatches), .points_pending(points_pending),
		.points_checked(points_checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= steady || ($urandom_range(99) >= 24);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		while (!steady && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		px <= x;
		py <= y;
		pz <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (points_pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_rotation(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] oz, input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az);
		drain();
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_ANGLE_X, {16'($urandom_range(65535)), ax});
		write_reg(CFG_ANGLE_Y, {16'd0, ay});
		write_reg(CFG_ANGLE_Z, {16'hFFFF, az});
		write_reg(3'd6 + 3'($urandom_range(1)), $urandom);
		settings_run++;
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
			2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
				: 32'h8000_0000 + $urandom_range(3);
			3: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
			default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 46080) - 23040);
			2: return 16'(5760 * $urandom_range(0, 8) - 23040);
			default: return 16'($urandom_range(0, 64) - 32);
		endcase
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h0, 32'h0, 32'h0);

		set_rotation(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd5760, 16'd11520, 16'd17280);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
		send_point(32'h0, 32'h0, 32'h7FFF_FFFF);

		set_rotation(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF,
			16'd23040);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
		send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);

		set_rotation(32'h0001_0000, 32'hFFFF_0000, 32'h0, -16'sd23040, 16'd2880, 16'd1);
		send_point(32'h0001_8000, 32'h0000_8000, 32'hFFFF_7FFF);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFD);

		for (int ph = 0; ph < 8; ph++) begin
			set_rotation(pick_coord(), pick_coord(), pick_coord(), pick_angle(),
				pick_angle(), pick_angle());
			steady = (ph == 3);
			for (int i = 0; i < 242; i++) begin
				send_point(pick_coord(), pick_coord(), pick_coord());
			end
			steady = 1'b0;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("checked %0d rotated points over %0d register settings", points_checked,
			settings_run);
		$display("extreme coordinates, wrapped angles and saturating origins included");
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/epr_pkg.sv
rtl/epr_trig.sv
rtl/epr_rotate.sv
rtl/euler_point_rotator_unit.sv
test/euler_point_rotator_checker.sv
test/euler_point_rotator_unit_tb.sv
